FILE: design/dec64_pkg.sv
package dec64_pkg;

    // Status codes of a result beat
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_BAD   = 2'd1;
    localparam logic [1:0] STATUS_RANGE = 2'd2;

    // Character codes
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_LOWER_E = 8'h65;
    localparam logic [7:0] CHAR_UPPER_E = 8'h45;

    // Exponent and digit count saturate here
    localparam logic [4:0] SAT_LIMIT = 5'd20;
    // Largest exponent + digit count that still fits (span of 20 digits)
    localparam logic [5:0] SPAN_LIMIT = 6'd20;

    // floor((2^64-1)/10); a digit step from above this overflows
    localparam logic [63:0] MUL10_LIMIT = 64'd1844674407370955161;
    // Last digit of 2^64-1; a larger digit at the limit also overflows
    localparam logic [3:0] MAX_LAST_DIGIT = 4'd5;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Input beat
    typedef struct packed {
        logic [7:0] character;
        logic       value_end;
    } in_beat_t;

    // Result beat
    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] parsed_value;
    } out_beat_t;

    // One finished value handed from front to back
    typedef struct packed {
        logic [1:0]  err;
        logic [63:0] mant;
        logic [4:0]  expo;
        logic [4:0]  cnt;
    } job_t;

    // Queue status seen by its neighbors
    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

endpackage

FILE: design/dec64_front.sv
module dec64_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  dec64_pkg::in_beat_t  s_data,
    input  dec64_pkg::queue_stat_t q_stat,
    output logic                 push,
    output dec64_pkg::job_t      job
);

    logic [63:0] mant_reg, mant_next;
    logic [4:0]  exp_reg, exp_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        seen_reg, seen_next;
    logic [1:0]  err_reg, err_next;

    logic        accept;
    logic        is_digit;
    logic        is_mark;
    logic [3:0]  digit;
    logic [8:0]  exp_wide;
    logic        mant_ovf;
    logic [63:0] mant_step;

    assign s_ready = !q_stat.full;
    assign accept  = s_valid && s_ready;
    assign push    = accept && s_data.value_end;

    assign job.err  = err_reg;
    assign job.mant = mant_reg;
    assign job.expo = exp_reg;
    assign job.cnt  = cnt_reg;

    // Character classification
    assign is_digit = (s_data.character >= dec64_pkg::CHAR_ZERO) &&
                      (s_data.character <= dec64_pkg::CHAR_NINE);
    assign is_mark  = (s_data.character == dec64_pkg::CHAR_LOWER_E) ||
                      (s_data.character == dec64_pkg::CHAR_UPPER_E);
    assign digit    = 4'(s_data.character - dec64_pkg::CHAR_ZERO);

    // Digit steps: mantissa shift-add with bound check, exponent saturating
    assign mant_ovf  = (mant_reg > dec64_pkg::MUL10_LIMIT) ||
                       ((mant_reg == dec64_pkg::MUL10_LIMIT) &&
                        (digit > dec64_pkg::MAX_LAST_DIGIT));
    assign mant_step = (mant_reg << 3) + (mant_reg << 1) + 64'(digit);
    assign exp_wide  = (9'(exp_reg) << 3) + (9'(exp_reg) << 1) + 9'(digit);

    always_comb begin
        mant_next = mant_reg;
        exp_next  = exp_reg;
        cnt_next  = cnt_reg;
        seen_next = seen_reg;
        err_next  = err_reg;
        if (accept) begin
            if (s_data.value_end) begin
                // value closed: back to the empty state
                mant_next = '0;
                exp_next  = '0;
                cnt_next  = '0;
                seen_next = 1'b0;
                err_next  = dec64_pkg::STATUS_OK;
            end else if (err_reg == dec64_pkg::STATUS_OK) begin
                if (is_digit) begin
                    if (seen_reg) begin
                        exp_next = (exp_wide > 9'(dec64_pkg::SAT_LIMIT)) ?
                                   dec64_pkg::SAT_LIMIT : exp_wide[4:0];
                    end else if (mant_ovf) begin
                        err_next = dec64_pkg::STATUS_RANGE;
                    end else begin
                        mant_next = mant_step;
                        if (cnt_reg < dec64_pkg::SAT_LIMIT) begin
                            cnt_next = cnt_reg + 5'd1;
                        end
                    end
                end else if (is_mark) begin
                    if (seen_reg || (cnt_reg == 5'd0)) begin
                        err_next = dec64_pkg::STATUS_BAD;
                    end else begin
                        seen_next = 1'b1;
                    end
                end else begin
                    err_next = dec64_pkg::STATUS_BAD;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mant_reg <= '0;
            exp_reg  <= '0;
            cnt_reg  <= '0;
            seen_reg <= 1'b0;
            err_reg  <= dec64_pkg::STATUS_OK;
        end else begin
            mant_reg <= mant_next;
            exp_reg  <= exp_next;
            cnt_reg  <= cnt_next;
            seen_reg <= seen_next;
            err_reg  <= err_next;
        end
    end

endmodule

FILE: design/dec64_fifo.sv
module dec64_fifo #(
    parameter int Depth = dec64_pkg::QUEUE_DEPTH
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  dec64_pkg::job_t        wr_job,
    input  logic                   pop,
    output dec64_pkg::job_t        rd_job,
    output dec64_pkg::queue_stat_t q_stat
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
    localparam logic [CntW-1:0] CntFull = CntW'(Depth);

    dec64_pkg::job_t mem_reg [Depth];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;

    assign q_stat.full  = (count_reg == CntFull);
    assign q_stat.empty = (count_reg == '0);
    assign rd_job       = mem_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PtrLast) ? '0 : wr_ptr_reg + PtrW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PtrLast) ? '0 : rd_ptr_reg + PtrW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CntW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CntW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_job;
        end
    end

endmodule

FILE: design/dec64_back.sv
module dec64_back (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  dec64_pkg::queue_stat_t q_stat,
    input  dec64_pkg::job_t        job,
    output logic                   pop,
    output logic                   m_valid,
    input  logic                   m_ready,
    output dec64_pkg::out_beat_t   m_data
);

    logic        busy_reg, busy_next;
    logic [4:0]  steps_reg, steps_next;
    logic [63:0] val_reg, val_next;
    logic [1:0]  status_reg, status_next;
    logic        m_valid_reg, m_valid_next;
    dec64_pkg::out_beat_t m_data_reg, m_data_next;

    logic       out_free;
    logic       finish;
    logic [5:0] span;

    assign out_free = !m_valid_reg || m_ready;
    assign finish   = busy_reg && (steps_reg == 5'd0) && out_free;
    assign pop      = !q_stat.empty && (!busy_reg || finish);
    assign span     = 6'(job.expo) + 6'(job.cnt);

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        busy_next    = busy_reg;
        steps_next   = steps_reg;
        val_next     = val_reg;
        status_next  = status_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        // Hand a finished value to the output register
        if (finish) begin
            m_valid_next             = 1'b1;
            m_data_next.status       = status_reg;
            m_data_next.parsed_value = (status_reg == dec64_pkg::STATUS_OK) ?
                                       val_reg : 64'd0;
            busy_next                = 1'b0;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end

        if (pop) begin
            // Load a job and decide how many scaling steps it needs
            busy_next   = 1'b1;
            val_next    = job.mant;
            status_next = job.err;
            steps_next  = '0;
            if (job.err == dec64_pkg::STATUS_OK && job.expo != 5'd0) begin
                if (span > dec64_pkg::SPAN_LIMIT) begin
                    status_next = dec64_pkg::STATUS_RANGE;
                end else begin
                    steps_next = job.expo;
                end
            end
        end else if (busy_reg && steps_reg != 5'd0) begin
            // One multiply by ten per cycle, stop on overflow
            if (val_reg > dec64_pkg::MUL10_LIMIT) begin
                status_next = dec64_pkg::STATUS_RANGE;
                steps_next  = '0;
            end else begin
                val_next   = (val_reg << 3) + (val_reg << 1);
                steps_next = steps_reg - 5'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            steps_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            steps_reg   <= steps_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        val_reg    <= val_next;
        status_reg <= status_next;
        m_data_reg <= m_data_next;
    end

endmodule

FILE: design/decimal_uint64_with_exponent_parser_top.sv
// Character beats are taken one per cycle and cause no result; the input stalls only
// while the queue between front and back is full of finished values.
// An end beat's value goes through the queue to the back end, which scales it by its
// exponent e (1..19), one multiply by ten per step, with fewer steps on overflow and
// none without exponent, on error or when the span check fails. It takes no new value
// until the last result enters the result register. Reset (aresetn, synchronous,
// active low) clears the parse state, the queue and the result valid.
module decimal_uint64_with_exponent_parser_top #(
    parameter int QueueDepth = dec64_pkg::QUEUE_DEPTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  dec64_pkg::in_beat_t  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output dec64_pkg::out_beat_t m_data
);

    dec64_pkg::queue_stat_t q_stat;
    dec64_pkg::job_t        wr_job;
    dec64_pkg::job_t        rd_job;
    logic                   push;
    logic                   pop;

    // Front: classify characters, accumulate, queue finished values
    dec64_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_stat  (q_stat),
        .push    (push),
        .job     (wr_job)
    );

    dec64_fifo #(
        .Depth (QueueDepth)
    ) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .wr_job  (wr_job),
        .pop     (pop),
        .rd_job  (rd_job),
        .q_stat  (q_stat)
    );

    // Back: range check, exponent scaling, result register
    dec64_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_stat  (q_stat),
        .job     (rd_job),
        .pop     (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Queue is never written while full
    assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !q_stat.full)
        else $error("queue written while full");

    // Queue is never read while empty
    assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !q_stat.empty)
        else $error("queue read while empty");

    // A failed parse always carries a zero value
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status != dec64_pkg::STATUS_OK) |->
            (m_data.parsed_value == 64'd0))
        else $error("error result with nonzero value");

endmodule
